@@ rtl/wsd_pkg.sv @@
// Package with the shared types and constants of the WebSocket frame deframer.
`timescale 1ns / 1ps

package wsd_pkg;

    // Second-byte length codes that select an extended length field.
    localparam logic [6:0] CODE_LEN16 = 7'h7e;
    localparam logic [6:0] CODE_LEN64 = 7'h7f;

    // Number of bytes in each extended length field and in the mask key.
    localparam logic [3:0] LEN16_BYTES = 4'd2;
    localparam logic [3:0] LEN64_BYTES = 4'd8;
    localparam logic [3:0] KEY_BYTES   = 4'd4;

    // Parser phases, one-hot.
    typedef enum logic [4:0] {
        PH_BYTE0   = 5'b00001,
        PH_BYTE1   = 5'b00010,
        PH_EXTLEN  = 5'b00100,
        PH_KEY     = 5'b01000,
        PH_PAYLOAD = 5'b10000
    } wsd_phase_t;

    // One classified result handed from the parser to the output side.
    // For payload beats, data and key are the raw byte and its key byte;
    // for header beats both are zero.
    typedef struct packed {
        logic        is_payload;
        logic        fin;
        logic [2:0]  rsv;
        logic [3:0]  opcode;
        logic        masked;
        logic [63:0] length;
        logic [7:0]  data;
        logic [7:0]  key;
        logic        last;
    } wsd_cmd_t;

    // Occupancy flags of the command queue.
    typedef struct packed {
        logic full;
        logic empty;
    } wsd_qstat_t;

endpackage

@@ rtl/wsd_byte_if.sv @@
// Interface for the received byte stream.
`timescale 1ns / 1ps

interface wsd_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;

    modport source (output valid, output data_byte, input ready);
    modport sink   (input valid, input data_byte, output ready);
endinterface

@@ rtl/wsd_result_if.sv @@
// Interface for the deframed header and payload results.
`timescale 1ns / 1ps

interface wsd_result_if;
    logic        valid;
    logic        ready;
    logic        is_payload;
    logic        final_flag;
    logic [2:0]  reserved_bits;
    logic [3:0]  frame_opcode;
    logic        mask_present;
    logic [63:0] frame_length;
    logic [7:0]  payload_byte;
    logic        frame_last;

    modport source (
        output valid, output is_payload, output final_flag, output reserved_bits,
        output frame_opcode, output mask_present, output frame_length,
        output payload_byte, output frame_last, input ready
    );
    modport sink (
        input valid, input is_payload, input final_flag, input reserved_bits,
        input frame_opcode, input mask_present, input frame_length,
        input payload_byte, input frame_last, output ready
    );
endinterface

@@ rtl/wsd_front.sv @@
// Header parser: walks the frame phases and classifies each byte into a command.
`timescale 1ns / 1ps

module wsd_front (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              byte_valid,
    input  logic [7:0]        byte_data,
    input  wsd_pkg::wsd_qstat_t qstat,
    output logic              byte_ready,
    output logic              push,
    output wsd_pkg::wsd_cmd_t push_cmd
);

    wsd_pkg::wsd_phase_t phase_reg, phase_next;
    logic [3:0]  cnt_reg, cnt_next;
    logic        fin_reg, fin_next;
    logic [2:0]  rsv_reg, rsv_next;
    logic [3:0]  opc_reg, opc_next;
    logic        masked_reg, masked_next;
    logic [63:0] len_reg, len_next;
    logic [31:0] key_reg, key_next;
    logic [63:0] remain_reg, remain_next;
    logic [1:0]  kidx_reg, kidx_next;

    logic        accept;
    logic        hdr_done;
    logic        length_done;
    logic [7:0]  key_byte;

    // A byte is taken whenever the queue has room for its possible result.
    assign byte_ready = !qstat.full;
    assign accept     = byte_valid && byte_ready;

    // Key byte for the current payload position, first key byte first.
    always_comb
    begin
        case (kidx_reg)
            2'd0:    key_byte = key_reg[31:24];
            2'd1:    key_byte = key_reg[23:16];
            2'd2:    key_byte = key_reg[15:8];
            default: key_byte = key_reg[7:0];
        endcase
    end

    // Phase step for one accepted byte.
    always_comb
    begin
        phase_next  = phase_reg;
        cnt_next    = cnt_reg;
        fin_next    = fin_reg;
        rsv_next    = rsv_reg;
        opc_next    = opc_reg;
        masked_next = masked_reg;
        len_next    = len_reg;
        key_next    = key_reg;
        remain_next = remain_reg;
        kidx_next   = kidx_reg;
        hdr_done    = 1'b0;
        length_done = 1'b0;
        push        = 1'b0;
        push_cmd    = '0;

        if (accept)
        begin
            case (phase_reg)
                wsd_pkg::PH_BYTE1:
                begin
                    masked_next = byte_data[7];
                    len_next    = '0;
                    if (byte_data[6:0] == wsd_pkg::CODE_LEN16)
                    begin
                        phase_next = wsd_pkg::PH_EXTLEN;
                        cnt_next   = wsd_pkg::LEN16_BYTES;
                    end
                    else if (byte_data[6:0] == wsd_pkg::CODE_LEN64)
                    begin
                        phase_next = wsd_pkg::PH_EXTLEN;
                        cnt_next   = wsd_pkg::LEN64_BYTES;
                    end
                    else
                    begin
                        len_next    = {57'd0, byte_data[6:0]};
                        length_done = 1'b1;
                    end
                end

                wsd_pkg::PH_EXTLEN:
                begin
                    len_next = {len_reg[55:0], byte_data};
                    cnt_next = cnt_reg - 4'd1;
                    if (cnt_next == 4'd0)
                    begin
                        length_done = 1'b1;
                    end
                end

                wsd_pkg::PH_KEY:
                begin
                    key_next = {key_reg[23:0], byte_data};
                    cnt_next = cnt_reg - 4'd1;
                    if (cnt_next == 4'd0)
                    begin
                        hdr_done = 1'b1;
                    end
                end

                wsd_pkg::PH_PAYLOAD:
                begin
                    remain_next         = remain_reg - 64'd1;
                    kidx_next           = kidx_reg + 2'd1;
                    push                = 1'b1;
                    push_cmd.is_payload = 1'b1;
                    push_cmd.data       = byte_data;
                    push_cmd.key        = masked_reg ? key_byte : 8'd0;
                    push_cmd.last       = (remain_next == 64'd0);
                    if (remain_next == 64'd0)
                    begin
                        phase_next = wsd_pkg::PH_BYTE0;
                        kidx_next  = 2'd0;
                    end
                end

                default:
                begin
                    fin_next   = byte_data[7];
                    rsv_next   = byte_data[6:4];
                    opc_next   = byte_data[3:0];
                    phase_next = wsd_pkg::PH_BYTE1;
                    cnt_next   = 4'd0;
                end
            endcase

            // Length known: read the mask key or close the header.
            if (length_done)
            begin
                if (masked_next)
                begin
                    phase_next = wsd_pkg::PH_KEY;
                    cnt_next   = wsd_pkg::KEY_BYTES;
                    key_next   = '0;
                end
                else
                begin
                    hdr_done = 1'b1;
                end
            end

            // Header complete: one header beat, then payload or next frame.
            if (hdr_done)
            begin
                remain_next         = len_next;
                kidx_next           = 2'd0;
                cnt_next            = 4'd0;
                phase_next          = (len_next == 64'd0) ? wsd_pkg::PH_BYTE0
                                                          : wsd_pkg::PH_PAYLOAD;
                push                = 1'b1;
                push_cmd.is_payload = 1'b0;
                push_cmd.last       = (len_next == 64'd0);
            end

            push_cmd.fin    = fin_next;
            push_cmd.rsv    = rsv_next;
            push_cmd.opcode = opc_next;
            push_cmd.masked = masked_next;
            push_cmd.length = len_next;
        end
    end

    // Parser state registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= wsd_pkg::PH_BYTE0;
            cnt_reg    <= '0;
            fin_reg    <= 1'b0;
            rsv_reg    <= '0;
            opc_reg    <= '0;
            masked_reg <= 1'b0;
            len_reg    <= '0;
            key_reg    <= '0;
            remain_reg <= '0;
            kidx_reg   <= '0;
        end
        else
        begin
            phase_reg  <= phase_next;
            cnt_reg    <= cnt_next;
            fin_reg    <= fin_next;
            rsv_reg    <= rsv_next;
            opc_reg    <= opc_next;
            masked_reg <= masked_next;
            len_reg    <= len_next;
            key_reg    <= key_next;
            remain_reg <= remain_next;
            kidx_reg   <= kidx_next;
        end
    end

endmodule

@@ rtl/wsd_queue.sv @@
// Two-entry command queue between the parser and the output stage.
`timescale 1ns / 1ps

module wsd_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  wsd_pkg::wsd_cmd_t   push_cmd,
    input  logic                pop,
    output wsd_pkg::wsd_cmd_t   head_cmd,
    output wsd_pkg::wsd_qstat_t qstat
);

    wsd_pkg::wsd_cmd_t slot_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;

    assign qstat.full  = (count_reg == 2'd2);
    assign qstat.empty = (count_reg == 2'd0);
    assign head_cmd    = slot_reg[rd_ptr_reg];

    // Pointer and occupancy update.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ push;
        rd_ptr_next = rd_ptr_reg ^ pop;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

@@ rtl/wsd_back.sv @@
// Output stage: unmasks payload bytes and holds each result beat until taken.
`timescale 1ns / 1ps

module wsd_back (
    input  logic                clk,
    input  logic                rst_n,
    input  wsd_pkg::wsd_cmd_t   head_cmd,
    input  wsd_pkg::wsd_qstat_t qstat,
    output logic                pop,
    wsd_result_if.source        result_ch
);

    logic              valid_reg, valid_next;
    wsd_pkg::wsd_cmd_t out_reg;
    logic [7:0]        byte_reg;

    // Load a new beat when the output register is empty or being drained.
    assign pop        = !qstat.empty && (!valid_reg || result_ch.ready);
    assign valid_next = pop || (valid_reg && !result_ch.ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Payload register with the unmasking XOR in front of it.
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            out_reg  <= head_cmd;
            byte_reg <= head_cmd.data ^ head_cmd.key;
        end
    end

    assign result_ch.valid         = valid_reg;
    assign result_ch.is_payload    = out_reg.is_payload;
    assign result_ch.final_flag    = out_reg.fin;
    assign result_ch.reserved_bits = out_reg.rsv;
    assign result_ch.frame_opcode  = out_reg.opcode;
    assign result_ch.mask_present  = out_reg.masked;
    assign result_ch.frame_length  = out_reg.length;
    assign result_ch.payload_byte  = byte_reg;
    assign result_ch.frame_last    = out_reg.last;

endmodule

@@ rtl/websocket_frame_deframer_core.sv @@
// Top level of the WebSocket frame deframer.
`timescale 1ns / 1ps

// Receives a WebSocket byte stream, one byte per beat, and splits it into
// frames: each frame gives one header beat (fin, reserved bits, opcode, mask
// flag and decoded length) once its header is complete, then one beat per
// payload byte, unmasked with the mask key and with frame_last on the final
// byte. A zero-length frame gives only its header beat, marked last. Header
// bytes before the end of the header give no beat. The block takes one byte
// every clock cycle while the queue is not full; that rate is set by the
// parser, which updates its phase, length and key state for each accepted
// byte. Each result passes through a two-entry queue and then an output
// register, which separate the parser from the result side, so bytes keep
// flowing while a result waits to be taken, until the queue holds two more
// results; the input then stalls until the output register is drained.
// Reserved bits, opcodes and length encodings pass through unchecked.
module websocket_frame_deframer_core (
    input logic         clk,
    input logic         rst_n,
    wsd_byte_if.sink    byte_ch,
    wsd_result_if.source result_ch
);

    logic                push;
    logic                pop;
    wsd_pkg::wsd_cmd_t   push_cmd;
    wsd_pkg::wsd_cmd_t   head_cmd;
    wsd_pkg::wsd_qstat_t qstat;
    logic                byte_ready;

    assign byte_ch.ready = byte_ready;

    // Header parser and byte classifier.
    wsd_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .byte_valid (byte_ch.valid),
        .byte_data  (byte_ch.data_byte),
        .qstat      (qstat),
        .byte_ready (byte_ready),
        .push       (push),
        .push_cmd   (push_cmd)
    );

    // Command queue.
    wsd_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (pop),
        .head_cmd (head_cmd),
        .qstat    (qstat)
    );

    // Unmasking and output register.
    wsd_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .head_cmd  (head_cmd),
        .qstat     (qstat),
        .pop       (pop),
        .result_ch (result_ch)
    );

endmodule
